### hw/rtl/tsct_pkg.sv
// shared types and constants for the taylor sine/cosine/tangent unit
// no dependencies; imported by the controller, datapath and top level
package tsct_pkg;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = 48;
  localparam int TERMS_W = 7;
  localparam int THR_W   = 20;
  localparam int M_W     = 62;   // term magnitude, capped at 2^61
  localparam int X2_W    = 48;   // x squared, holds any fraction width in range
  localparam int ACC_W   = 110;  // M_W + X2_W
  localparam int DIV_W   = 110;  // dividend / quotient shift register
  localparam int SUM_W   = 64;
  localparam int DVS_W   = 63;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    OP_SIN = 2'd0,
    OP_COS = 2'd1,
    OP_TAN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_INIT,
    ST_ADD,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_UPDATE,
    ST_SER_END,
    ST_TLOAD,
    ST_TDIV,
    ST_TFIN,
    ST_FIN,
    ST_FZERO
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       square;
    logic       init_series;
    logic       series_cos;
    logic       add_term;
    logic       mul_step;
    logic [1:0] mul_sel;
    logic       div_load_term;
    logic       div_load_tan;
    logic       div_step;
    logic       term_update;
    logic       save_sine;
    logic       fin_plain;
    logic       fin_tan;
    logic       fin_tan_zero;
    logic       fin_zero;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic last_term;
    logic term_small;
    logic cos_zero;
  } dp_stat_t;

endpackage

### hw/rtl/taylor_sine_cosine_tangent_unit.sv
// top level of the taylor sine/cosine/tangent unit
// depends on tsct_pkg, tsct_controller and tsct_datapath
//
// an item (op, angle in radians, no range reduction) is taken when start is
// high and busy is low; busy then stays high until the result is produced.
// the result shows on out_* for exactly one cycle with out_valid high, in the
// same cycle that busy drops, and cannot be held off by the receiver.
// each series term costs an add, four steps on the shared 32x32 multiplier,
// a divider load, (110 - FRAC_BITS) bit-per-cycle divide steps and an update.
// sine or cosine squares the angle, then runs its terms and a finish step;
// tangent runs both series and then a load, a 63 + FRAC_BITS step division
// of sine by cosine and a finish step, or ends at the load on a zero cosine.
// an unused op code ends after the square step with an all-zero result. the
// threshold register may only be written while busy is low.
module taylor_sine_cosine_tangent_unit import tsct_pkg::*; #(
  parameter int MAX_TERMS = 48,
  parameter int FRAC_BITS = 28
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_op,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic                      cfg_we,
  input  logic [THR_W-1:0]          cfg_data,
  output logic                      out_valid,
  output logic signed [OUT_W-1:0]   out_value,
  output logic                      out_saturated,
  output logic [TERMS_W-1:0]        out_terms_used
);

  // command and status between the sequencer and the arithmetic
  dp_cmd_t  cmd;
  dp_stat_t stat;

  tsct_controller #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .stat (stat),
    .cmd  (cmd)
  );

  tsct_datapath #(
    .MAX_TERMS(MAX_TERMS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_op         (in_op),
    .in_angle      (in_angle),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_value     (out_value),
    .out_saturated (out_saturated),
    .out_terms_used(out_terms_used)
  );

  // an accepted item always makes the unit busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("item accepted but unit not busy");

  // a result strobe only ever follows a busy cycle
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a busy cycle before it");

  // finishing an item always produces exactly one result
  a_fell_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result");

  // never more terms than the configured limit
  a_terms_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_terms_used <= TERMS_W'(MAX_TERMS))
    else $error("term count above limit");

endmodule

### hw/rtl/tsct_controller.sv
// sequencing state machine for the taylor sine/cosine/tangent unit
// depends on tsct_pkg; drives the datapath through dp_cmd_t
module tsct_controller import tsct_pkg::*; #(
  parameter int FRAC_BITS = 28
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [CNT_W-1:0] TERM_STEPS = CNT_W'(DIV_W - FRAC_BITS);
  localparam logic [CNT_W-1:0] TAN_STEPS  = CNT_W'(DVS_W + FRAC_BITS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             cos_r, cos_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      cos_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      cos_r   <= cos_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cos_nxt   = cos_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        // op of the item is registered by now
        state_nxt = (stat.op == OP_NONE) ? ST_FZERO : ST_INIT;
        cos_nxt   = (stat.op == OP_COS);
      end
      ST_INIT: state_nxt = ST_ADD;
      ST_ADD: begin
        cnt_nxt   = '0;
        state_nxt = stat.last_term ? ST_SER_END : ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(3)) state_nxt = ST_DLOAD;
      end
      ST_DLOAD: begin
        cnt_nxt   = TERM_STEPS;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: state_nxt = stat.term_small ? ST_SER_END : ST_ADD;
      ST_SER_END: begin
        if (stat.op == OP_TAN && !cos_r) begin
          cos_nxt   = 1'b1;
          state_nxt = ST_INIT;
        end else if (stat.op == OP_TAN) begin
          state_nxt = ST_TLOAD;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_TLOAD: begin
        cnt_nxt   = TAN_STEPS;
        state_nxt = stat.cos_zero ? ST_IDLE : ST_TDIV;
      end
      ST_TDIV: begin
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) state_nxt = ST_TFIN;
      end
      ST_TFIN:  state_nxt = ST_IDLE;
      ST_FIN:   state_nxt = ST_IDLE;
      ST_FZERO: state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd            = '0;
    cmd.series_cos = cos_r;
    cmd.mul_sel    = cnt_r[1:0];
    busy           = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:    cmd.load_in = start;
      ST_SQUARE:  cmd.square = 1'b1;
      ST_INIT:    cmd.init_series = 1'b1;
      ST_ADD:     cmd.add_term = 1'b1;
      ST_MUL:     cmd.mul_step = 1'b1;
      ST_DLOAD:   cmd.div_load_term = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_UPDATE:  cmd.term_update = 1'b1;
      ST_SER_END: cmd.save_sine = (stat.op == OP_TAN) && !cos_r;
      ST_TLOAD: begin
        cmd.div_load_tan = !stat.cos_zero;
        cmd.fin_tan_zero = stat.cos_zero;
      end
      ST_TDIV:    cmd.div_step = 1'b1;
      ST_TFIN:    cmd.fin_tan = 1'b1;
      ST_FIN:     cmd.fin_plain = 1'b1;
      ST_FZERO:   cmd.fin_zero = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

### hw/rtl/tsct_datapath.sv
// series datapath: shared multiplier, restoring divider, sum and result registers
// depends on tsct_pkg; commanded by tsct_controller
module tsct_datapath import tsct_pkg::*; #(
  parameter int MAX_TERMS = 48,
  parameter int FRAC_BITS = 28
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_stat_t                 stat,
  input  logic [1:0]               in_op,
  input  logic signed [ANGLE_W-1:0] in_angle,
  input  logic                     cfg_we,
  input  logic [THR_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic signed [OUT_W-1:0]  out_value,
  output logic                     out_saturated,
  output logic [TERMS_W-1:0]       out_terms_used
);

  localparam logic [M_W-1:0]   TERM_CAP = M_W'(1) << 61;
  localparam logic [DIV_W-1:0] Q_CAP    = DIV_W'(1) << 61;
  localparam logic [DIV_W-1:0] Q_OMAX   = (DIV_W'(1) << (OUT_W - 1)) - 1'b1;
  localparam logic [DIV_W-1:0] Q_OMIN   = DIV_W'(1) << (OUT_W - 1);
  localparam logic signed [SUM_W:0] SUM_CAP = (SUM_W + 1)'(1) << 62;
  localparam logic signed [SUM_W-1:0] OUT_MAX = (SUM_W'(1) << (OUT_W - 1)) - 1'b1;
  localparam logic signed [SUM_W-1:0] OUT_MIN = -(SUM_W'(1) << (OUT_W - 1));

  logic [THR_W-1:0]        thr_r;
  op_t                     op_r;
  logic [ANGLE_W-1:0]      ax_r;
  logic                    xneg_r;
  logic [X2_W-1:0]         x2_r;
  logic [M_W-1:0]          m_r, m_nxt;
  logic                    neg_r;
  logic signed [SUM_W-1:0] sum_r, s_r;
  logic [TERMS_W-1:0]      terms_r, ts_r;
  logic [6:0]              i_r;
  logic [ACC_W-1:0]        acc_r;
  logic [DIV_W-1:0]        q_r;
  logic [SUM_W-1:0]        rem_r;
  logic [DVS_W-1:0]        dvsr_r;
  logic                    ovf_r;
  logic                    valid_r;
  logic signed [OUT_W-1:0] value_r;
  logic                    sat_r;
  logic [TERMS_W-1:0]      tu_r;

  // shared 32x32 multiplier
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        mul_p;
  logic [ACC_W-1:0]   pp_shift;
  always_comb begin
    if (cmd.square) begin
      mul_a = ax_r;
      mul_b = ax_r;
    end else begin
      mul_a = cmd.mul_sel[0] ? {2'b00, m_r[61:32]} : m_r[31:0];
      mul_b = cmd.mul_sel[1] ? {16'h0000, x2_r[47:32]} : x2_r[31:0];
    end
    mul_p    = mul_a * mul_b;
    pp_shift = ACC_W'(mul_p) << (7'd32 * ({6'd0, cmd.mul_sel[0]} + {6'd0, cmd.mul_sel[1]}));
  end

  // term add with clamp
  logic signed [SUM_W:0] t_ext, s_ext, s_new;
  logic                  s_hi, s_lo;
  always_comb begin
    t_ext = $signed({3'b000, m_r});
    s_ext = {sum_r[SUM_W-1], sum_r};
    s_new = neg_r ? (s_ext - t_ext) : (s_ext + t_ext);
    s_hi  = (s_new > SUM_CAP);
    s_lo  = (s_new < -SUM_CAP);
  end

  // divisor of the next term
  logic [7:0]  k;
  logic [15:0] d_term;
  always_comb begin
    k      = cmd.series_cos ? ({i_r, 1'b0} - 8'd1) : {i_r, 1'b0};
    d_term = k * (k + 8'd1);
  end

  // restoring divider step
  logic [SUM_W-1:0] rs;
  logic             q_bit;
  always_comb begin
    rs    = {rem_r[SUM_W-2:0], q_r[DIV_W-1]};
    q_bit = (rs >= {1'b0, dvsr_r});
  end

  // next term magnitude
  logic q_big;
  always_comb begin
    q_big = (q_r > Q_CAP);
    m_nxt = q_big ? TERM_CAP : q_r[M_W-1:0];
  end

  logic [SUM_W-1:0] ms, mc;
  logic             tneg;
  always_comb begin
    ms   = s_r[SUM_W-1] ? -s_r : s_r;
    mc   = sum_r[SUM_W-1] ? -sum_r : sum_r;
    tneg = s_r[SUM_W-1] != sum_r[SUM_W-1];
  end

  always_comb begin
    stat.op         = op_r;
    stat.last_term  = ({1'b0, terms_r} + 8'd1) >= 8'(MAX_TERMS);
    stat.term_small = (m_nxt <= M_W'(thr_r));
    stat.cos_zero   = (sum_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= THR_W'(1);
      valid_r <= 1'b0;
    end else begin
      if (cfg_we) thr_r <= cfg_data;
      valid_r <= cmd.fin_plain | cmd.fin_tan | cmd.fin_tan_zero | cmd.fin_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= op_t'(in_op);
      xneg_r <= in_angle[ANGLE_W-1];
      ax_r   <= in_angle[ANGLE_W-1] ? -in_angle : in_angle;
      ovf_r  <= 1'b0;
    end
    if (cmd.square) x2_r <= X2_W'(mul_p >> FRAC_BITS);
    if (cmd.init_series) begin
      m_r     <= cmd.series_cos ? (M_W'(1) << FRAC_BITS) : M_W'(ax_r);
      neg_r   <= cmd.series_cos ? 1'b0 : xneg_r;
      sum_r   <= '0;
      terms_r <= '0;
      i_r     <= 7'd1;
    end
    if (cmd.add_term) begin
      terms_r <= terms_r + 1'b1;
      if (s_hi) begin
        sum_r <= SUM_CAP[SUM_W-1:0];
        ovf_r <= 1'b1;
      end else if (s_lo) begin
        sum_r <= -SUM_CAP[SUM_W-1:0];
        ovf_r <= 1'b1;
      end else begin
        sum_r <= s_new[SUM_W-1:0];
      end
    end
    if (cmd.mul_step) begin
      acc_r <= (cmd.mul_sel == 2'd0) ? pp_shift : (acc_r + pp_shift);
    end
    if (cmd.div_load_term) begin
      // dividend is acc >> FRAC_BITS, left aligned in the shift register
      q_r    <= {acc_r[ACC_W-1:FRAC_BITS], FRAC_BITS'(0)};
      rem_r  <= '0;
      dvsr_r <= DVS_W'(d_term);
    end
    if (cmd.div_load_tan) begin
      q_r    <= {ms[DVS_W-1:0], (DIV_W - DVS_W)'(0)};
      rem_r  <= '0;
      dvsr_r <= mc[DVS_W-1:0];
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[DIV_W-2:0], q_bit};
      rem_r <= q_bit ? (rs - {1'b0, dvsr_r}) : rs;
    end
    if (cmd.term_update) begin
      m_r   <= m_nxt;
      neg_r <= ~neg_r;
      i_r   <= i_r + 1'b1;
      if (q_big) ovf_r <= 1'b1;
    end
    if (cmd.save_sine) begin
      s_r  <= sum_r;
      ts_r <= terms_r;
    end
    if (cmd.fin_plain) begin
      tu_r <= terms_r;
      if (sum_r > OUT_MAX) begin
        value_r <= OUT_MAX[OUT_W-1:0];
        sat_r   <= 1'b1;
      end else if (sum_r < OUT_MIN) begin
        value_r <= OUT_MIN[OUT_W-1:0];
        sat_r   <= 1'b1;
      end else begin
        value_r <= sum_r[OUT_W-1:0];
        sat_r   <= ovf_r;
      end
    end
    if (cmd.fin_tan_zero) begin
      tu_r    <= (ts_r > terms_r) ? ts_r : terms_r;
      sat_r   <= 1'b1;
      value_r <= s_r[SUM_W-1] ? OUT_MIN[OUT_W-1:0] : OUT_MAX[OUT_W-1:0];
    end
    if (cmd.fin_tan) begin
      tu_r <= (ts_r > terms_r) ? ts_r : terms_r;
      if (tneg) begin
        if (q_r > Q_OMIN) begin
          value_r <= OUT_MIN[OUT_W-1:0];
          sat_r   <= 1'b1;
        end else begin
          value_r <= -q_r[OUT_W-1:0];
          sat_r   <= ovf_r;
        end
      end else begin
        if (q_r > Q_OMAX) begin
          value_r <= OUT_MAX[OUT_W-1:0];
          sat_r   <= 1'b1;
        end else begin
          value_r <= q_r[OUT_W-1:0];
          sat_r   <= ovf_r;
        end
      end
    end
    if (cmd.fin_zero) begin
      value_r <= '0;
      sat_r   <= 1'b0;
      tu_r    <= '0;
    end
  end

  assign out_valid      = valid_r;
  assign out_value      = value_r;
  assign out_saturated  = sat_r;
  assign out_terms_used = tu_r;

endmodule

### test/tb_taylor_sine_cosine_tangent_unit.sv
// testbench for the taylor sine/cosine/tangent unit: directed and random items
// checked against a bit-exact fixed-point series predictor held in this file
// depends on tsct_pkg and taylor_sine_cosine_tangent_unit
module tb_taylor_sine_cosine_tangent_unit;
  import tsct_pkg::*;

  localparam int  FRAC       = 28;
  localparam int  TERM_LIMIT = 48;
  localparam int  LATENCY    = 20;
  localparam longint CYCLE_LIMIT = 40_000_000;

  // one expected result of the block
  typedef struct {
    logic signed [OUT_W-1:0] value;
    logic                    saturated;
    logic [TERMS_W-1:0]      terms_used;
  } trig_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_op;
  logic signed [ANGLE_W-1:0] in_angle;
  logic                      cfg_we;
  logic [THR_W-1:0]          cfg_data;
  logic                      out_valid;
  logic signed [OUT_W-1:0]   out_value;
  logic                      out_saturated;
  logic [TERMS_W-1:0]        out_terms_used;

  // predictor copy of the threshold register
  logic [THR_W-1:0] stop_threshold;
  trig_result_t     pending_results[$];
  int               mismatch_count;
  longint           cycle_count;

  taylor_sine_cosine_tangent_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_angle       (in_angle),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_saturated  (out_saturated),
    .out_terms_used (out_terms_used)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sums one taylor series the way the hardware does: magnitudes truncated,
  // sign flipped per term, stop on small term or on the term limit
  function automatic void sum_series(input bit cosine, input longint x,
                                     input logic [THR_W-1:0] thr,
                                     output longint total, output int count,
                                     inout bit ovf);
    logic [63:0]  ax, x2, mag, d;
    logic [127:0] prod, quot;
    longint       idx;
    bit           neg;
    ax    = (x < 0) ? -x : x;
    x2    = (ax * ax) >> FRAC;
    mag   = cosine ? (64'd1 << FRAC) : ax;
    neg   = cosine ? 1'b0 : (x < 0);
    total = 0;
    count = 0;
    idx   = 1;
    while (1) begin
      total = neg ? total - longint'(mag) : total + longint'(mag);
      // running sum held to +-2^62
      if (total > (64'sd1 <<< 62)) begin
        total = 64'sd1 <<< 62;
        ovf = 1'b1;
      end
      if (total < -(64'sd1 <<< 62)) begin
        total = -(64'sd1 <<< 62);
        ovf = 1'b1;
      end
      count++;
      if (count >= TERM_LIMIT) break;
      d    = cosine ? (2*idx - 1) * (2*idx) : (2*idx) * (2*idx + 1);
      prod = {64'd0, mag} * {64'd0, x2};
      quot = prod / ({64'd0, d} << FRAC);
      // term magnitude capped at 2^61
      if (quot > (128'd1 << 61)) begin
        mag = 64'd1 << 61;
        ovf = 1'b1;
      end else begin
        mag = quot[63:0];
      end
      neg = !neg;
      idx++;
      if (mag <= {44'd0, thr}) break;
    end
  endfunction

  function automatic trig_result_t predict_trig(input op_t op,
                                                input logic signed [ANGLE_W-1:0] angle);
    trig_result_t r;
    longint       x, s, c, v;
    int           ns, nc;
    bit           ovf;
    logic [63:0]  ms, mc;
    logic [127:0] quot;
    bit           neg;
    longint       out_max, out_min;
    out_max = (64'sd1 <<< 47) - 1;
    out_min = -(64'sd1 <<< 47);
    x   = angle;
    ovf = 1'b0;
    v   = 0;
    ns  = 0;
    case (op)
      OP_SIN, OP_COS: begin
        sum_series(op == OP_COS, x, stop_threshold, s, ns, ovf);
        // output clamp to the 48-bit range
        if (s > out_max) begin
          v = out_max;
          ovf = 1'b1;
        end else if (s < out_min) begin
          v = out_min;
          ovf = 1'b1;
        end else begin
          v = s;
        end
      end
      OP_TAN: begin
        sum_series(1'b0, x, stop_threshold, s, ns, ovf);
        sum_series(1'b1, x, stop_threshold, c, nc, ovf);
        if (nc > ns) ns = nc;
        if (c == 0) begin
          // zero cosine: saturate towards the sign of sine
          ovf = 1'b1;
          v = (s >= 0) ? out_max : out_min;
        end else begin
          ms   = (s < 0) ? -s : s;
          mc   = (c < 0) ? -c : c;
          neg  = (s < 0) != (c < 0);
          quot = ({64'd0, ms} << FRAC) / {64'd0, mc};
          if (neg) begin
            if (quot > (128'd1 << 47)) begin
              ovf = 1'b1;
              v = out_min;
            end else begin
              v = -longint'(quot[63:0]);
            end
          end else begin
            if (quot > 128'(out_max)) begin
              ovf = 1'b1;
              v = out_max;
            end else begin
              v = longint'(quot[63:0]);
            end
          end
        end
      end
      default: begin
        // unused op code gives all zeros
        v  = 0;
        ns = 0;
      end
    endcase
    r.value      = v[OUT_W-1:0];
    r.saturated  = ovf;
    r.terms_used = ns[TERMS_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s: got %0d, expected %0d at cycle %0d", what, got, want,
             cycle_count);
    mismatch_count++;
  endtask

  // result checker: every strobed result against the oldest expectation
  always @(posedge clk) begin
    trig_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result value", out_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_value !== want.value)
          report_mismatch("value", out_value, want.value);
        if (out_saturated !== want.saturated)
          report_mismatch("saturated", out_saturated, want.saturated);
        if (out_terms_used !== want.terms_used)
          report_mismatch("terms_used", out_terms_used, want.terms_used);
      end
    end
  end

  // cycle guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sends one item, waits for it to be taken, then a random gap
  task automatic send_item(input op_t op, input logic signed [ANGLE_W-1:0] angle);
    int gap;
    in_op    <= op;
    in_angle <= angle;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(predict_trig(op, angle));
    gap = $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lets everything in flight come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] thr);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    stop_threshold = thr;
  endtask

  // reset threshold, angle extremes, every op and the unused op code
  task automatic test_directed();
    logic signed [ANGLE_W-1:0] angles[8];
    angles = '{32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sd268435456,
               -32'sd268435456, 32'sd421657428, 32'sd1, -32'sd1};
    foreach (angles[k]) begin
      send_item(OP_SIN, angles[k]);
      send_item(OP_COS, angles[k]);
    end
    // pi/2 neighbourhood drives the cosine near zero for tangent
    send_item(OP_TAN, 32'sd0);
    send_item(OP_TAN, 32'sd421657428);
    send_item(OP_TAN, -32'sd421657428);
    send_item(OP_TAN, 32'sh7fff_ffff);
    send_item(OP_TAN, 32'sh8000_0000);
    send_item(OP_NONE, 32'sh7fff_ffff);
    send_item(OP_NONE, 32'sh8000_0000);
  endtask

  // zero and full-scale thresholds
  task automatic test_threshold_extremes();
    write_threshold('0);
    send_item(OP_SIN, 32'sd0);
    send_item(OP_COS, 32'sd268435456);
    send_item(OP_TAN, -32'sd134217728);
    write_threshold('1);
    send_item(OP_SIN, 32'sh7fff_ffff);
    send_item(OP_COS, 32'sh8000_0000);
    send_item(OP_TAN, 32'sd421657428);
  endtask

  function automatic logic signed [ANGLE_W-1:0] random_angle();
    int sel;
    sel = $urandom_range(0, 9);
    // mostly within about +-2 rad, full range now and then
    if (sel == 0) return $urandom;
    return $signed($urandom) >>> $urandom_range(2, 6);
  endfunction

  function automatic op_t random_op();
    if ($urandom_range(0, 15) == 0) return OP_NONE;
    return op_t'($urandom_range(0, 2));
  endfunction

  // random items in phases of different thresholds
  task automatic test_random(input int n_items);
    logic [THR_W-1:0] thr_set[6];
    thr_set = '{20'd1, 20'd0, 20'hfffff, 20'd16, 20'(($urandom)), 20'($urandom_range(0, 4095))};
    foreach (thr_set[p]) begin
      write_threshold(thr_set[p]);
      for (int k = 0; k < n_items / 6; k++) begin
        send_item(random_op(), random_angle());
        // a full drain partway through the phase with threshold 16
        if (p == 3 && k == n_items / 12) drain_results();
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = '0;
    in_angle       = '0;
    cfg_we         = 1'b0;
    cfg_data       = '0;
    stop_threshold = 20'd1;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_threshold_extremes();
    test_random(1230);
    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/tsct_pkg.sv
hw/rtl/tsct_controller.sv
hw/rtl/tsct_datapath.sv
hw/rtl/taylor_sine_cosine_tangent_unit.sv
test/tb_taylor_sine_cosine_tangent_unit.sv
